/* rtl/sap_pkg.sv */
package sap_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DELAY   = 4096;
  localparam int SAMPLE_BITS = 24;

  // Register field widths
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Coefficient limits, Q0.16
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd58982;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd45875;

  // Delay limits and reset value, in samples
  localparam int DELAY_MIN   = 2;
  localparam int DELAY_RESET = 2;

  // Product rounding: add one half LSB, then drop the fraction bits
  localparam int ROUND_BITS = 16;
  localparam int ROUND_HALF = 32768;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 1'b0,
    CFG_DELAY = 1'b1
  } cfg_idx_e;

endpackage

/* rtl/sap_in_if.sv */
interface sap_in_if #(
  parameter int SampleBits = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* rtl/sap_out_if.sv */
interface sap_out_if #(
  parameter int SampleBits = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_out;
  logic                         saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

/* rtl/schroeder_allpass_filter.sv */
// Schroeder allpass filter, one sample in and one sample out per transfer.
// The result is registered at each stage and leaves from the stage 5 result register.
// Throughput: 1 sample per cycle; the pipeline holds while the result is not taken.
// The delay store is one 1R1W memory with a registered read; stage 3 forwards.
// Reset sets the settings, pointers and valids at once; a fill count makes unwritten
// entries read as zero, so there is no clearing pass.
module schroeder_allpass_filter import sap_pkg::*; #(
  parameter int MaxDelay   = MAX_DELAY,
  parameter int SampleBits = SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sap_in_if.sink               in_if,
  sap_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int AddrW = $clog2(MaxDelay);
  localparam int CntW  = AddrW + 1;
  localparam int XW    = AddrW + 2;

  logic [GAIN_W-1:0]  gain_q, gain_wr;
  logic [CntW-1:0]    delay_q, delay_wr;
  logic [DELAY_W-1:0] delay_fld;
  logic [AddrW-1:0]   wp_q;
  logic [CntW-1:0]    fill_q;
  logic [XW-1:0]      wp_x, d_x, rd_x;
  logic [AddrW-1:0]   rd_addr;
  logic               hit;
  logic               en, accept;

  logic                  mem_wr_en;
  logic [AddrW-1:0]      mem_wr_addr;
  logic [SampleBits-1:0] mem_wr_data, mem_rd_data;

  // Clamp register writes into their legal range
  assign gain_wr   = (cfg_data_i[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : cfg_data_i[GAIN_W-1:0];
  assign delay_fld = cfg_data_i[DELAY_W-1:0];

  always_comb begin
    if (32'(delay_fld) > 32'(MaxDelay)) begin
      delay_wr = CntW'(MaxDelay);
    end else if (32'(delay_fld) < 32'(DELAY_MIN)) begin
      delay_wr = CntW'(DELAY_MIN);
    end else begin
      delay_wr = CntW'(delay_fld);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      delay_q <= CntW'(DELAY_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:  gain_q  <= gain_wr;
        CFG_DELAY: delay_q <= delay_wr;
        default: ;
      endcase
    end
  end

  // Hold the whole pipeline while the result waits
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;
  assign accept      = in_if.valid && en;

  // Read position trails the write position by the delay, modulo the depth
  assign wp_x    = XW'(wp_q);
  assign d_x     = XW'(delay_q);
  assign rd_x    = (wp_x >= d_x) ? (wp_x - d_x) : (wp_x + XW'(MaxDelay) - d_x);
  assign rd_addr = rd_x[AddrW-1:0];

  // Entries below the fill count have been written since reset
  assign hit = (fill_q == CntW'(MaxDelay)) || (CntW'(rd_addr) < fill_q);

  // Advance the write position and fill count on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (accept) begin
      wp_q <= (CntW'(wp_q) == CntW'(MaxDelay - 1)) ? '0 : wp_q + AddrW'(1);
      if (fill_q != CntW'(MaxDelay)) begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  sap_delay_mem #(
    .Depth (MaxDelay),
    .Width (SampleBits)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  sap_datapath #(
    .SampleBits (SampleBits),
    .AddrW      (AddrW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (accept),
    .sample_i      (in_if.sample_in),
    .rd_addr_i     (rd_addr),
    .wr_addr_i     (wp_q),
    .hit_i         (hit),
    .gain_i        (gain_q),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .out_valid_o   (out_if.valid),
    .sample_o      (out_if.sample_out),
    .sat_o         (out_if.saturated)
  );

  // Stored delay always lies in its legal range
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q >= CntW'(DELAY_MIN) && delay_q <= CntW'(MaxDelay))
    else $error("delay register out of range");

  // Before the store wraps, the write position equals the fill count
  a_fill_tracks_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != CntW'(MaxDelay) |-> CntW'(wp_q) == fill_q)
    else $error("fill count and write position disagree");

  // The gain register never exceeds its ceiling
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= GAIN_MAX)
    else $error("gain register above ceiling");

endmodule

/* rtl/sap_delay_mem.sv */
module sap_delay_mem #(
  parameter int Depth = 4096,
  parameter int Width = 24,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // One write port, one registered read port; a same-edge read returns old data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sap_datapath.sv */
module sap_datapath import sap_pkg::*; #(
  parameter int SampleBits = 24,
  parameter int AddrW      = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic [AddrW-1:0]             rd_addr_i,
  input  logic [AddrW-1:0]             wr_addr_i,
  input  logic                         hit_i,
  input  logic [GAIN_W-1:0]            gain_i,
  input  logic [SampleBits-1:0]        mem_rd_data_i,
  output logic                         mem_wr_en_o,
  output logic [AddrW-1:0]             mem_wr_addr_o,
  output logic [SampleBits-1:0]        mem_wr_data_o,
  output logic                         out_valid_o,
  output logic signed [SampleBits-1:0] sample_o,
  output logic                         sat_o
);

  localparam int SW = SampleBits;
  localparam int PW = SW + GAIN_W + 1;
  localparam int RW = PW - ROUND_BITS;

  localparam logic signed [SW+1:0] SatHi = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] SatLo = {3'b111, {(SW-1){1'b0}}};

  // Stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: read data arrives
  logic signed [SW-1:0] x1_q;
  logic [AddrW-1:0]     ra1_q, wa1_q;
  logic                 hit1_q;
  logic                 fwd1;
  logic signed [SW-1:0] dly1;
  logic signed [PW-1:0] p1;

  // Stage 2: state sum and write-back
  logic signed [SW-1:0] x2_q, dly2_q;
  logic [AddrW-1:0]     wa2_q;
  logic signed [PW-1:0] p2_q, p2_rnd;
  logic signed [RW-1:0] r2;
  logic signed [SW+1:0] st_raw;
  logic signed [SW-1:0] st_d;
  logic                 st_clip;

  // Stage 3: feed-forward product
  logic signed [SW-1:0] dly3_q, st3_q;
  logic [AddrW-1:0]     wa3_q;
  logic                 f3_q;
  logic signed [PW-1:0] q3;

  // Stage 4: output difference
  logic signed [SW-1:0] dly4_q;
  logic signed [PW-1:0] q4_q, q4_rnd;
  logic                 f4_q;
  logic signed [RW-1:0] r4;
  logic signed [SW+1:0] y_raw;
  logic signed [SW-1:0] y_d;
  logic                 y_clip;

  // Stage 5: result register
  logic signed [SW-1:0] y5_q;
  logic                 sat5_q;

  // Forward the state written on the edge that issued this read; the item
  // one ahead can never match since the delay is at least two
  assign fwd1 = v3_q && (wa3_q == ra1_q);

  always_comb begin
    if (fwd1) begin
      dly1 = st3_q;
    end else if (hit1_q) begin
      dly1 = $signed(mem_rd_data_i);
    end else begin
      dly1 = '0;
    end
  end

  assign p1 = $signed({1'b0, gain_i}) * dly1;

  // Round the feedback product and saturate the state
  assign p2_rnd = p2_q + PW'(ROUND_HALF);
  assign r2     = RW'(p2_rnd >>> ROUND_BITS);
  assign st_raw = (SW+2)'(x2_q) + (SW+2)'(r2);

  always_comb begin
    st_clip = 1'b1;
    if (st_raw > SatHi) begin
      st_d = SatHi[SW-1:0];
    end else if (st_raw < SatLo) begin
      st_d = SatLo[SW-1:0];
    end else begin
      st_d    = st_raw[SW-1:0];
      st_clip = 1'b0;
    end
  end

  // Write the state back as the item leaves stage 2
  assign mem_wr_en_o   = en_i && v2_q;
  assign mem_wr_addr_o = wa2_q;
  assign mem_wr_data_o = st_d;

  assign q3 = $signed({1'b0, gain_i}) * st3_q;

  // Round the feed-forward product and saturate the output
  assign q4_rnd = q4_q + PW'(ROUND_HALF);
  assign r4     = RW'(q4_rnd >>> ROUND_BITS);
  assign y_raw  = (SW+2)'(dly4_q) - (SW+2)'(r4);

  always_comb begin
    y_clip = 1'b1;
    if (y_raw > SatHi) begin
      y_d = SatHi[SW-1:0];
    end else if (y_raw < SatLo) begin
      y_d = SatLo[SW-1:0];
    end else begin
      y_d    = y_raw[SW-1:0];
      y_clip = 1'b0;
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= sample_i;
      ra1_q  <= rd_addr_i;
      wa1_q  <= wr_addr_i;
      hit1_q <= hit_i;

      x2_q   <= x1_q;
      dly2_q <= dly1;
      wa2_q  <= wa1_q;
      p2_q   <= p1;

      dly3_q <= dly2_q;
      st3_q  <= st_d;
      wa3_q  <= wa2_q;
      f3_q   <= st_clip;

      dly4_q <= dly3_q;
      q4_q   <= q3;
      f4_q   <= f3_q;

      y5_q   <= y_d;
      sat5_q <= f4_q | y_clip;
    end
  end

  assign out_valid_o = v5_q;
  assign sample_o    = y5_q;
  assign sat_o       = sat5_q;

  // The item one ahead never writes the entry a new read needs
  a_no_near_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q |-> wa2_q != ra1_q)
    else $error("read in stage 1 aliases the write of stage 2");

  // A write-back is visible in stage 3 for forwarding on the next cycle
  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en_o |=> v3_q && wa3_q == $past(mem_wr_addr_o))
    else $error("forwarding stage lost the written entry");

endmodule

/* tb/sv/allpass_checker.sv */
module allpass_checker import sap_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_i,
  input  logic                          out_saturated_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   outstanding_o,
  output int unsigned                   compared_o,
  output int unsigned                   clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SampleHi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SampleLo = -SampleHi - 1;
  localparam int     IdxW     = $clog2(MAX_DELAY);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          saturated;
  } filter_out_t;

  // Shadow copy of the filter state and its two registers
  logic signed [SAMPLE_BITS-1:0] echo_mem [MAX_DELAY];
  logic [IdxW-1:0]               write_idx;
  logic [GAIN_W-1:0]             gain_q;
  logic [DELAY_W-1:0]            delay_q;
  filter_out_t                   pending_samples_q [$];

  // Multiply by the Q0.16 gain, round to nearest with ties toward plus infinity
  function automatic longint scale_by_gain(input logic [GAIN_W-1:0] g, input longint v);
    return (longint'(g) * v + longint'(ROUND_HALF)) >>> ROUND_BITS;
  endfunction

  // Clip to the sample range and raise the flag on any clipping
  function automatic longint clip_sample(input longint v, inout logic hit);
    if (v > SampleHi) begin
      hit = 1'b1;
      return SampleHi;
    end
    if (v < SampleLo) begin
      hit = 1'b1;
      return SampleLo;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_filter
    logic [GAIN_W-1:0] g;
    int unsigned       span;
    logic [IdxW-1:0]   read_idx;
    longint            tap;
    longint            fed;
    longint            y;
    logic              hit;
    filter_out_t       want;
    int unsigned       errs;
    if (!rst_ni) begin
      echo_mem  = '{default: '0};
      write_idx = '0;
      gain_q    = GAIN_RESET;
      delay_q   = DELAY_W'(DELAY_RESET);
      pending_samples_q.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
      compared_o       <= 0;
      clipped_o        <= 0;
    end else begin
      errs = 0;

      // Follow register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN:  gain_q = cfg_data_i[GAIN_W-1:0];
          CFG_DELAY: delay_q = cfg_data_i[DELAY_W-1:0];
          default: ;
        endcase
      end

      // Predict the output of each input transfer and write the state back
      if (in_valid_i && in_ready_i) begin
        g    = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
        span = 32'(delay_q);
        if (span < DELAY_MIN) span = DELAY_MIN;
        if (span > MAX_DELAY) span = MAX_DELAY;
        read_idx = IdxW'((32'(write_idx) + MAX_DELAY - span) % MAX_DELAY);
        tap = longint'(echo_mem[read_idx]);
        hit = 1'b0;
        fed = clip_sample(longint'(in_sample_i) + scale_by_gain(g, tap), hit);
        y   = clip_sample(tap - scale_by_gain(g, fed), hit);
        echo_mem[write_idx] = fed[SAMPLE_BITS-1:0];
        write_idx = IdxW'((32'(write_idx) + 1) % MAX_DELAY);
        want.sample    = y[SAMPLE_BITS-1:0];
        want.saturated = hit;
        pending_samples_q.push_back(want);
      end

      // Compare each output transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_samples_q.size() == 0) begin
          $display("%0t: unexpected output, expected none, got sample %0d saturated %0b",
                   $time, out_sample_i, out_saturated_i);
          errs++;
        end else begin
          want = pending_samples_q.pop_front();
          if (out_sample_i !== want.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want.sample, out_sample_i);
            errs++;
          end
          if (out_saturated_i !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, out_saturated_i);
            errs++;
          end
          compared_o <= compared_o + 1;
          if (want.saturated) clipped_o <= clipped_o + 1;
        end
      end

      mismatch_count_o <= mismatch_count_o + errs;
      outstanding_o    <= pending_samples_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sap_pkg::*;

  localparam int          ClockHalf    = 5;
  localparam int          ResetCycles  = 7;
  localparam int          PhaseCount   = 12;
  localparam int          PhaseItems   = 155;
  localparam int          CalmPhases   = 2;
  localparam int          PressPhase   = 3;
  localparam int          PressItems   = 80;
  localparam int          DrainPhase   = 6;
  localparam int          HoldCycles   = 300;
  localparam int          SettleCycles = 8;
  localparam int          TailCycles   = 20;
  localparam int unsigned CycleLimit   = 400000;

  localparam logic signed [SAMPLE_BITS-1:0] SampleHi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleLo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    STIM_WIDE,
    STIM_QUIET,
    STIM_LOUD,
    STIM_MIXED
  } stim_style_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  sap_in_if  #(.SampleBits(SAMPLE_BITS)) in_ch ();
  sap_out_if #(.SampleBits(SAMPLE_BITS)) out_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned clipped;
  int unsigned samples_sent;
  int unsigned settings_loaded;
  int unsigned cycle_count;
  bit          calm;
  bit          rx_hold_req;
  bit          rx_hold_done;
  bit          loud_high;

  schroeder_allpass_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  allpass_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_sample_i      (in_ch.sample_in),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_sample_i     (out_ch.sample_out),
    .out_saturated_i  (out_ch.saturated),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .compared_o       (compared),
    .clipped_o        (clipped)
  );

  always begin
    #ClockHalf clk_i = 1'b1;
    #ClockHalf clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d outputs outstanding",
               cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Pick one input sample in the style of the current phase
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input stim_style_e style);
    logic signed [SAMPLE_BITS-1:0] v;
    case (style)
      STIM_QUIET: v = SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
      STIM_LOUD: begin
        // flip polarity now and then so the state rides both rails
        if ($urandom_range(0, 24) == 0) loud_high = !loud_high;
        v = loud_high ? SampleHi - SAMPLE_BITS'($urandom_range(0, 4095))
                      : SampleLo + SAMPLE_BITS'($urandom_range(0, 4095));
      end
      STIM_MIXED: begin
        case ($urandom_range(0, 5))
          0:       v = SampleHi;
          1:       v = SampleLo;
          2:       v = '0;
          3:       v = 1;
          4:       v = -1;
          default: v = SAMPLE_BITS'($urandom);
        endcase
      end
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // Offer one sample, maybe after an idle burst, and hold it until the transfer
  task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit allow_gap);
    logic took;
    if (allow_gap && !calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted output has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write gain then delay on back-to-back cycles
  task automatic load_settings(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] delay);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_GAIN;
    cfg_data_i <= gain;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DELAY;
    cfg_data_i <= delay;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_loaded++;
  endtask

  // Pace the output side: random stalls, open stretches, one long hold on request
  initial begin : pace_output
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !rx_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : drive_stimulus
    logic [CFG_W-1:0] gain_val;
    logic [CFG_W-1:0] delay_val;
    stim_style_e      style;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_GAIN;
    cfg_data_i      <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero, both rails, unit steps, then sustained rails to clip
    offer_sample('0, 1'b1);
    offer_sample(SampleHi, 1'b1);
    offer_sample(SampleLo, 1'b1);
    offer_sample(1, 1'b1);
    offer_sample(-1, 1'b1);
    repeat (4) offer_sample(SampleHi, 1'b1);
    repeat (3) offer_sample(SampleLo, 1'b1);

    // Half gain on odd taps lands products exactly on the rounding tie
    wait_idle();
    load_settings(CFG_W'(32768), CFG_W'(3));
    offer_sample(1, 1'b1);
    offer_sample(-1, 1'b1);
    offer_sample(3, 1'b1);
    offer_sample(-3, 1'b1);
    offer_sample(5, 1'b1);
    offer_sample(-5, 1'b1);
    repeat (2) offer_sample('0, 1'b1);

    // Gain above its limit and a zero delay both get clamped
    wait_idle();
    load_settings('1, '0);
    repeat (2) offer_sample(SampleHi, 1'b1);
    repeat (2) offer_sample(SampleLo, 1'b1);
    offer_sample(SampleHi, 1'b1);

    // Random phases, each under its own gain and delay
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          gain_val  = '0;
          delay_val = CFG_W'(DELAY_MIN);
        end
        1: begin
          gain_val  = GAIN_MAX;
          delay_val = CFG_W'(MAX_DELAY);
        end
        2: begin
          gain_val  = '1;
          delay_val = CFG_W'(1);
        end
        3: begin
          gain_val  = CFG_W'(GAIN_MAX + 1);
          delay_val = '1;
        end
        4: begin
          gain_val  = CFG_W'($urandom_range(0, GAIN_MAX));
          delay_val = CFG_W'($urandom_range(2, 12));
        end
        5: begin
          gain_val  = GAIN_RESET;
          delay_val = '0;
        end
        6: begin
          gain_val  = CFG_W'($urandom);
          delay_val = CFG_W'($urandom_range(13, 300));
        end
        7: begin
          gain_val  = CFG_W'(1);
          delay_val = CFG_W'(MAX_DELAY + 1);
        end
        8: begin
          gain_val  = CFG_W'($urandom_range(GAIN_MAX - 100, GAIN_MAX));
          delay_val = CFG_W'($urandom_range(2, 40));
        end
        9: begin
          gain_val  = CFG_W'(32768);
          delay_val = CFG_W'(DELAY_MIN);
        end
        10: begin
          gain_val  = CFG_W'($urandom_range(GAIN_MAX / 2, GAIN_MAX));
          delay_val = CFG_W'($urandom_range(2, 8));
        end
        default: begin
          gain_val  = GAIN_MAX;
          delay_val = CFG_W'(3);
        end
      endcase
      load_settings(gain_val, delay_val);
      calm  = (phase >= PhaseCount - CalmPhases);
      style = stim_style_e'(phase % 4);
      if (phase == PressPhase) rx_hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        // pause the input mid-phase until the pipeline has emptied
        if (phase == DrainPhase && n == PhaseItems / 2) wait_idle();
        offer_sample(draw_sample(style), !(phase == PressPhase && n < PressItems));
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d samples under %0d register settings; %0d outputs checked, %0d clipped.",
             samples_sent, settings_loaded, compared, clipped);
    $display("Exercised gain and delay clamps, rounding ties, both rails, a %0d-cycle %s",
             HoldCycles, "output hold and a mid-stream drain.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sap_pkg.sv
rtl/sap_in_if.sv
rtl/sap_out_if.sv
rtl/sap_delay_mem.sv
rtl/sap_datapath.sv
rtl/schroeder_allpass_filter.sv
tb/sv/allpass_checker.sv
tb/sv/tb_top.sv
